### src/ilex_pkg.sv
// Shared types and constants for the integer literal lexer.
`default_nettype none

package ilex_pkg;

  // Width of the token length count and its saturation value.
  localparam int unsigned LEN_W = 16;
  localparam logic [LEN_W-1:0] LENGTH_LIMIT = 16'd65535;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_ACC_EXCL = 3'd1,
    ST_ACC_INCL = 3'd2,
    ST_REJECT   = 3'd3,
    ST_IDLE     = 3'd4
  } status_e;

  // One input item as held in the input register.
  typedef struct packed {
    logic       start_scan;
    logic       literal_allowed;
    logic [7:0] character;
  } item_t;

  // One result item.
  typedef struct packed {
    status_e          status;
    logic [LEN_W-1:0] token_length;
  } result_t;

endpackage

`default_nettype wire

### src/ilex_if.sv
// Valid/ready channel interfaces for the lexer's input and result streams.
`default_nettype none

interface ilex_in_if;
  logic       valid;
  logic       ready;
  logic       start_scan;
  logic       literal_allowed;
  logic [7:0] character;

  modport source (output valid, output start_scan, output literal_allowed,
                  output character, input ready);
  modport sink (input valid, input start_scan, input literal_allowed,
                input character, output ready);
endinterface

interface ilex_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] token_length;

  modport source (output valid, output status, output token_length, input ready);
  modport sink (input valid, input status, input token_length, output ready);
endinterface

`default_nettype wire

### src/ilex_in_reg.sv
// Input register: captures one character item per transfer.
`default_nettype none

module ilex_in_reg
  import ilex_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ilex_in_if.sink    in_i,
  input  wire logic  adv_i,
  output item_t      item_o,
  output logic       valid_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  // Room when empty or when the held item moves on this cycle.
  assign in_i.ready = !valid_q || adv_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{start_scan: in_i.start_scan, literal_allowed: in_i.literal_allowed,
                  character: in_i.character};
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

### src/ilex_step.sv
// Scan automaton: phase and length registers with their next-state logic.
`default_nettype none

module ilex_step
  import ilex_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  item_t      item_i,
  output result_t    res_o
);

  // Automaton phases.
  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_BLANK = 5'd1;
  localparam logic [4:0] PH_ZERO  = 5'd2;
  localparam logic [4:0] PH_CBIN0 = 5'd3;
  localparam logic [4:0] PH_CBIN  = 5'd4;
  localparam logic [4:0] PH_CHEX0 = 5'd5;
  localparam logic [4:0] PH_CHEX  = 5'd6;
  localparam logic [4:0] PH_COCT  = 5'd7;
  localparam logic [4:0] PH_DEC   = 5'd8;
  localparam logic [4:0] PH_MX    = 5'd9;
  localparam logic [4:0] PH_ML    = 5'd10;
  localparam logic [4:0] PH_ME    = 5'd11;
  localparam logic [4:0] PH_MN    = 5'd12;
  localparam logic [4:0] PH_MQ    = 5'd13;
  localparam logic [4:0] PH_VQ    = 5'd14;
  localparam logic [4:0] PH_VS    = 5'd15;
  localparam logic [4:0] PH_VD0   = 5'd16;
  localparam logic [4:0] PH_VDEC  = 5'd17;
  localparam logic [4:0] PH_VBIN0 = 5'd18;
  localparam logic [4:0] PH_VBIN  = 5'd19;
  localparam logic [4:0] PH_VOCT0 = 5'd20;
  localparam logic [4:0] PH_VOCT  = 5'd21;
  localparam logic [4:0] PH_VHEX0 = 5'd22;
  localparam logic [4:0] PH_VHEX  = 5'd23;

  // Character codes.
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HX = 8'h66;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;
  localparam logic [7:0] CH_USCR  = 8'h5F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_B_UP  = 8'h42;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_O_UP  = 8'h4F;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_D_UP  = 8'h44;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_H_UP  = 8'h48;

  logic [4:0]       phase_q, phase_d;
  logic [LEN_W-1:0] count_q, count_d;

  // Character classes.
  logic c_blank, c_dig, c_hex, c_xz, c_oct, c_bit;
  logic c_b, c_o, c_d, c_h, c_x, c_us, c_s, c_quote;

  // Step decode.
  logic [4:0]       ph, nxt;
  logic [LEN_W-1:0] cnt, cnt_new;
  logic             tk;
  status_e          st;

  always_comb begin
    c_blank = (item_i.character == CH_SP) || (item_i.character == CH_TAB) ||
              (item_i.character == CH_LF) || (item_i.character == CH_CR);
    c_dig   = (item_i.character >= CH_0) && (item_i.character <= CH_9);
    c_hex   = c_dig ||
              ((item_i.character >= CH_LA) && (item_i.character <= CH_LF_HX)) ||
              ((item_i.character >= CH_UA) && (item_i.character <= CH_UF));
    c_xz    = (item_i.character == CH_X) || (item_i.character == CH_X_UP) ||
              (item_i.character == CH_Z) || (item_i.character == CH_Z_UP);
    c_oct   = (item_i.character >= CH_0) && (item_i.character <= CH_7);
    c_bit   = (item_i.character == CH_0) || (item_i.character == CH_1);
    c_b     = (item_i.character == CH_B) || (item_i.character == CH_B_UP);
    c_o     = (item_i.character == CH_O) || (item_i.character == CH_O_UP);
    c_d     = (item_i.character == CH_D) || (item_i.character == CH_D_UP);
    c_h     = (item_i.character == CH_H) || (item_i.character == CH_H_UP);
    c_x     = (item_i.character == CH_X) || (item_i.character == CH_X_UP);
    c_us    = (item_i.character == CH_USCR);
    c_s     = (item_i.character == CH_S);
    c_quote = (item_i.character == CH_QUOTE);
  end

  // Automaton step for the held item.
  always_comb begin
    ph  = phase_q;
    cnt = count_q;
    st  = ST_IDLE;
    nxt = PH_IDLE;
    tk  = 1'b0;

    // A start flag drops any open scan and resets the count.
    if (item_i.start_scan) begin
      cnt = '0;
      ph  = item_i.literal_allowed ? PH_BLANK : PH_IDLE;
    end

    if (item_i.start_scan && !item_i.literal_allowed) begin
      st = ST_REJECT;
    end else begin
      unique case (ph)
        PH_BLANK: begin
          if (c_blank) begin
            st = ST_PENDING; nxt = PH_BLANK;
          end else if (item_i.character == CH_0) begin
            st = ST_PENDING; nxt = PH_ZERO; tk = 1'b1;
          end else if (c_dig) begin
            st = ST_PENDING; nxt = PH_DEC; tk = 1'b1;
          end else if (item_i.character == CH_M) begin
            st = ST_PENDING; nxt = PH_MX; tk = 1'b1;
          end else if (c_quote) begin
            st = ST_PENDING; nxt = PH_VQ; tk = 1'b1;
          end else begin
            st = ST_REJECT;
          end
        end
        PH_ZERO: begin
          if (c_b) begin
            st = ST_PENDING; nxt = PH_CBIN0; tk = 1'b1;
          end else if (c_x) begin
            st = ST_PENDING; nxt = PH_CHEX0; tk = 1'b1;
          end else if (c_oct) begin
            st = ST_PENDING; nxt = PH_COCT; tk = 1'b1;
          end else if (c_s) begin
            st = ST_ACC_INCL; tk = 1'b1;
          end else begin
            st = ST_ACC_EXCL;
          end
        end
        PH_CBIN0: begin
          if (c_bit) begin
            st = ST_PENDING; nxt = PH_CBIN; tk = 1'b1;
          end else begin
            st = ST_REJECT;
          end
        end
        PH_CBIN, PH_CHEX, PH_COCT, PH_DEC: begin
          if ((ph == PH_CBIN && (c_bit || c_us)) ||
              (ph == PH_CHEX && (c_hex || c_us)) ||
              (ph == PH_COCT && (c_oct || c_us)) ||
              (ph == PH_DEC && (c_dig || c_us))) begin
            st = ST_PENDING; nxt = ph; tk = 1'b1;
          end else if (ph == PH_DEC && c_quote) begin
            st = ST_PENDING; nxt = PH_VQ; tk = 1'b1;
          end else if (c_s) begin
            st = ST_ACC_INCL; tk = 1'b1;
          end else begin
            st = ST_ACC_EXCL;
          end
        end
        PH_CHEX0: begin
          if (c_hex) begin
            st = ST_PENDING; nxt = PH_CHEX; tk = 1'b1;
          end else begin
            st = ST_REJECT;
          end
        end
        // The fixed width prefix, one letter a step, then its quote.
        PH_MX, PH_ML, PH_ME, PH_MN, PH_MQ: begin
          if (ph == PH_MX && item_i.character == CH_X_UP) begin
            st = ST_PENDING; nxt = PH_ML; tk = 1'b1;
          end else if (ph == PH_ML && item_i.character == CH_L) begin
            st = ST_PENDING; nxt = PH_ME; tk = 1'b1;
          end else if (ph == PH_ME && item_i.character == CH_E) begin
            st = ST_PENDING; nxt = PH_MN; tk = 1'b1;
          end else if (ph == PH_MN && item_i.character == CH_N) begin
            st = ST_PENDING; nxt = PH_MQ; tk = 1'b1;
          end else if (ph == PH_MQ && c_quote) begin
            st = ST_PENDING; nxt = PH_VQ; tk = 1'b1;
          end else begin
            st = ST_REJECT;
          end
        end
        // After the quote, or after the quote and the signed marker.
        PH_VQ, PH_VS: begin
          if (ph == PH_VQ && c_s) begin
            st = ST_PENDING; nxt = PH_VS; tk = 1'b1;
          end else if (c_b) begin
            st = ST_PENDING; nxt = PH_VBIN0; tk = 1'b1;
          end else if (c_o) begin
            st = ST_PENDING; nxt = PH_VOCT0; tk = 1'b1;
          end else if (c_d) begin
            st = ST_PENDING; nxt = PH_VD0; tk = 1'b1;
          end else if (c_h) begin
            st = ST_PENDING; nxt = PH_VHEX0; tk = 1'b1;
          end else if (c_dig) begin
            st = ST_PENDING; nxt = PH_VDEC; tk = 1'b1;
          end else begin
            st = (ph == PH_VS) ? ST_ACC_EXCL : ST_REJECT;
          end
        end
        PH_VD0, PH_VDEC: begin
          if (c_dig || (ph == PH_VDEC && c_us)) begin
            st = ST_PENDING; nxt = PH_VDEC; tk = 1'b1;
          end else begin
            st = ST_ACC_EXCL;
          end
        end
        // Verilog digit runs: the first digit is required, later ones may be underscores.
        PH_VBIN0, PH_VBIN, PH_VOCT0, PH_VOCT, PH_VHEX0, PH_VHEX: begin
          if (((ph == PH_VBIN0 || ph == PH_VBIN) && (c_bit || c_xz)) ||
              ((ph == PH_VOCT0 || ph == PH_VOCT) && (c_oct || c_xz)) ||
              ((ph == PH_VHEX0 || ph == PH_VHEX) && (c_hex || c_xz)) ||
              ((ph == PH_VBIN || ph == PH_VOCT || ph == PH_VHEX) && c_us)) begin
            st = ST_PENDING;
            tk = 1'b1;
            if (ph == PH_VBIN0 || ph == PH_VBIN) begin
              nxt = PH_VBIN;
            end else if (ph == PH_VOCT0 || ph == PH_VOCT) begin
              nxt = PH_VOCT;
            end else begin
              nxt = PH_VHEX;
            end
          end else if (ph == PH_VBIN0 || ph == PH_VOCT0 || ph == PH_VHEX0) begin
            st = ST_REJECT;
          end else begin
            st = ST_ACC_EXCL;
          end
        end
        default: begin
          st = ST_IDLE;
        end
      endcase
    end

    // Saturating count of consumed characters.
    cnt_new = (tk && (cnt < LENGTH_LIMIT)) ? cnt + 1'b1 : cnt;

    phase_d = (st == ST_PENDING) ? nxt : PH_IDLE;
    count_d = cnt_new;

    res_o.status       = st;
    res_o.token_length = ((st == ST_ACC_EXCL) || (st == ST_ACC_INCL)) ? cnt_new : '0;
  end

  // A byte with no scan open leaves the count untouched; the logic above keeps it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

### src/ilex_out_reg.sv
// Result register: holds one result until the receiver takes it.
`default_nettype none

module ilex_out_reg
  import ilex_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  load_i,
  input  result_t    res_i,
  output logic       full_o,
  ilex_out_if.source out_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign full_o             = valid_q;
  assign out_o.valid        = valid_q;
  assign out_o.status       = res_q.status;
  assign out_o.token_length = res_q.token_length;

endmodule

`default_nettype wire

### src/integer_literal_lexer.sv
// Top level of the integer literal lexer: input register, automaton, result register.
//
// Usage: characters arrive on in_i, one byte per transfer, with start_scan
// opening a new scan and literal_allowed qualifying it; a zero byte marks the
// end of input. For every input transfer exactly one result leaves on out_o:
// a status (pending, accepted before or including this byte, rejected, idle)
// and the token length, which is nonzero only on an accept.
//
// An input transfer lands in the input register, where the automaton decodes
// the byte; the result register loads its result when the byte advances.
// Throughput is one byte per cycle while the receiver keeps taking results;
// the automaton phase and the saturating length counter update once per byte.
//
// Reset closes any scan, clears the length count and empties both registers.
// When the receiver stalls, the result register holds its item and the input
// register holds the next byte; in_i.ready drops only when both are full and
// the result is not being taken in that cycle.
`default_nettype none

module integer_literal_lexer
  import ilex_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ilex_in_if.sink    in_i,
  ilex_out_if.source out_o
);

  item_t   item;
  logic    item_valid;
  logic    out_full;
  logic    adv;
  result_t res;

  // The held byte advances when the result register is free or draining.
  assign adv = item_valid && (!out_full || out_o.ready);

  ilex_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .item_o  (item),
    .valid_o (item_valid)
  );

  ilex_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .item_i (item),
    .res_o  (res)
  );

  ilex_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (adv),
    .res_i  (res),
    .full_o (out_full),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
